// ----- rtl/lbbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbs_pkg
// Shared types, codes and the quarter-wave cosine function of the LED
// blink / breathe sequencer.
// ----------------------------------------------------------------------------
package lbbs_pkg;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_SET_VALUE  = 3'd1,
      OP_SET_SOLID  = 3'd2,
      OP_BLINK_ONCE = 3'd3,
      OP_BLINK_TWICE = 3'd4,
      OP_BLINK_CONT = 3'd5,
      OP_BREATHE    = 3'd6,
      OP_CLEAR      = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      MODE_SOLID   = 3'd0,
      MODE_ONCE    = 3'd1,
      MODE_TWICE   = 3'd2,
      MODE_CONT    = 3'd3,
      MODE_BREATHE = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_BLEND,
      ST_EMIT
   } seq_state_type;

   typedef enum logic [2:0] {
      EN_IDLE,
      EN_DIV,
      EN_LOOK,
      EN_WEIGHT,
      EN_MUL,
      EN_DONE
   } eng_state_type;

   // start of a breathe blend, with the operands captured by the engine
   typedef struct packed {
      logic        start;
      logic [15:0] elapsed;
      logic [15:0] len;
      logic [7:0]  from_lvl;
      logic [7:0]  to_lvl;
   } blend_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] duty;
   } blend_rsp_type;

   localparam logic [15:0] BLINK_TIME_RESET = 16'd100;
   localparam logic [15:0] LOOP_ENDLESS     = 16'hFFFF;
   localparam longint unsigned HALF_PI_Q30  = 64'h6487_ED51;
   localparam longint unsigned ONE_Q30      = 64'd1073741824;

   // cos(pi/2 * k / 2^qshift) in Q30, eleven-term Taylor series with the
   // divisors (2j-1)*2j written out; only evaluated at elaboration
   function automatic logic signed [31:0] quarter_cos(input int unsigned k,
                                                      input int unsigned qshift);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (HALF_PI_Q30 * longint'(k)) >> qshift;
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      sum  = longint'(ONE_Q30);
      term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 306; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 380; sum = sum + longint'(term);
      return 32'(sum);
   endfunction

endpackage

// ----- rtl/lbbs_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbs_req_if
// Command / tick channel of the LED sequencer, valid-ready handshake.
// ----------------------------------------------------------------------------
interface lbbs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [7:0]  color;
   logic [7:0]  end_color;
   logic [15:0] duration_ms;
   logic [15:0] period_ms;
   logic signed [15:0] loop_limit;

   modport source (output valid, opcode, color, end_color, duration_ms, period_ms,
                   loop_limit, input ready);
   modport sink   (input valid, opcode, color, end_color, duration_ms, period_ms,
                   loop_limit, output ready);
endinterface

// ----- rtl/lbbs_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbs_rsp_if
// Duty result channel of the LED sequencer, valid-ready handshake.
// ----------------------------------------------------------------------------
interface lbbs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] duty;

   modport source (output valid, duty, input ready);
   modport sink   (input valid, duty, output ready);
endinterface

// ----- rtl/lbbs_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbs_blend
// Breathe blend engine: bit-serial divide for the table index, cosine
// weight lookup, then two bit-serial multiplies for the level blend.
// ----------------------------------------------------------------------------
module lbbs_blend
   import lbbs_pkg::*;
#(
   parameter int COS_TABLE_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  blend_req_type blend_req,
   output blend_rsp_type blend_rsp
);

   localparam int QTR    = 1 << (COS_TABLE_BITS - 2);
   localparam int ITER   = (COS_TABLE_BITS > 8) ? COS_TABLE_BITS : 8;
   localparam int CNT_W  = $clog2(ITER);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(COS_TABLE_BITS - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(7);
   localparam logic signed [33:0] U_BIAS = 34'sd1073741824;
   localparam logic signed [33:0] U_MAX  = 34'sd2147483648;

   // quarter-wave cosine in Q30, entries 0..QTR
   logic signed [31:0] cos_tab [QTR+1];

   for (genvar g = 0; g <= QTR; g++) begin : g_tab
      assign cos_tab[g] = quarter_cos(g, COS_TABLE_BITS - 2);
   end

   eng_state_type             st_ff,  st_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [16:0]               rem_ff, rem_in;
   logic [COS_TABLE_BITS-1:0] quo_ff, quo_in;
   logic [15:0]               len_ff, len_in;
   logic [7:0]                from_ff, from_in;
   logic [7:0]                to_ff, to_in;
   logic signed [31:0]        cos_ff, cos_in;
   logic                      neg_ff, neg_in;
   logic [15:0]               t_ff, t_in;
   logic [23:0]               acc_a_ff, acc_a_in;
   logic [23:0]               acc_b_ff, acc_b_in;

   logic [16:0]               rem_sh;
   logic                      rem_ge;
   logic [COS_TABLE_BITS-2:0] tab_idx;
   logic signed [32:0]        s_val;
   logic signed [33:0]        u_val;
   logic [31:0]               u_clamp;
   logic [15:0]               t_comp;

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      len_in   = len_ff;
      from_in  = from_ff;
      to_in    = to_ff;
      cos_in   = cos_ff;
      neg_in   = neg_ff;
      t_in     = t_ff;
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      blend_rsp.done = 1'b0;
      blend_rsp.duty = 8'(acc_a_ff[22:15] + acc_b_ff[22:15]);

      // restoring divide step, one quotient bit per cycle
      rem_sh = {rem_ff[15:0], 1'b0};
      rem_ge = (rem_sh >= {1'b0, len_ff});

      // fold the index into the first quadrant
      if (quo_ff[COS_TABLE_BITS-2]) begin
         tab_idx = (COS_TABLE_BITS-1)'(QTR) - {1'b0, quo_ff[COS_TABLE_BITS-3:0]};
      end else begin
         tab_idx = {1'b0, quo_ff[COS_TABLE_BITS-3:0]};
      end

      // weight t = (clamp(s + 1.0) + rounding) >> 16, unsigned Q1.15
      s_val = neg_ff ? -{cos_ff[31], cos_ff} : {cos_ff[31], cos_ff};
      u_val = {s_val[32], s_val} + U_BIAS;
      if (u_val < 0) begin
         u_clamp = '0;
      end else if (u_val > U_MAX) begin
         u_clamp = 32'(U_MAX);
      end else begin
         u_clamp = u_val[31:0];
      end
      t_comp = 16'd32768 - t_ff;

      unique case (st_ff)
         EN_IDLE: begin
            if (blend_req.start) begin
               rem_in  = {1'b0, blend_req.elapsed};
               quo_in  = '0;
               cnt_in  = '0;
               len_in  = blend_req.len;
               from_in = blend_req.from_lvl;
               to_in   = blend_req.to_lvl;
               st_in   = EN_DIV;
            end
         end
         EN_DIV: begin
            rem_in = rem_ge ? (rem_sh - {1'b0, len_ff}) : rem_sh;
            quo_in = {quo_ff[COS_TABLE_BITS-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               st_in = EN_LOOK;
            end
         end
         EN_LOOK: begin
            cos_in = cos_tab[tab_idx];
            // second and third quadrants are negative
            neg_in = quo_ff[COS_TABLE_BITS-1] ^ quo_ff[COS_TABLE_BITS-2];
            st_in  = EN_WEIGHT;
         end
         EN_WEIGHT: begin
            t_in     = 16'((u_clamp + 32'd32768) >> 16);
            acc_a_in = '0;
            acc_b_in = '0;
            cnt_in   = '0;
            st_in    = EN_MUL;
         end
         EN_MUL: begin
            // MSB-first shift-add, one bit of each level per cycle
            acc_a_in = {acc_a_ff[22:0], 1'b0} + (from_ff[7] ? {8'd0, t_ff} : 24'd0);
            acc_b_in = {acc_b_ff[22:0], 1'b0} + (to_ff[7] ? {8'd0, t_comp} : 24'd0);
            from_in  = {from_ff[6:0], 1'b0};
            to_in    = {to_ff[6:0], 1'b0};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               st_in = EN_DONE;
            end
         end
         EN_DONE: begin
            blend_rsp.done = 1'b1;
            st_in          = EN_IDLE;
         end
         default: begin
            st_in = EN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= EN_IDLE;
      end else begin
         st_ff <= st_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      len_ff   <= len_in;
      from_ff  <= from_in;
      to_ff    <= to_in;
      cos_ff   <= cos_in;
      neg_ff   <= neg_in;
      t_ff     <= t_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
   end

endmodule

// ----- rtl/led_blink_breathe_sequencer_top.sv -----
`timescale 1ns / 1ps
// Path: a command puts its duty in the pending-duty register, then the emit
//   state moves it to the output register; a tick passes the tick state first,
//   a breathe tick also the blend engine (serial divide, table, serial multiply).
// Flow: one item at a time; the next transfer is taken once any result of the
//   previous item is in the output register, the emit state waiting on a full one.
// Reset: synchronous; solid mode, zero counters, blink time BLINK_TIME_RESET.
// ----------------------------------------------------------------------------
// led_blink_breathe_sequencer_top
// Single-channel LED effect sequencer: set, clear, blink and breathe commands and
// millisecond ticks in, PWM duty bytes out.
// ----------------------------------------------------------------------------
module led_blink_breathe_sequencer_top
   import lbbs_pkg::*;
#(
   parameter int COS_TABLE_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [15:0]   csr_wdata,
   lbbs_req_if.sink      req_ch,
   lbbs_rsp_if.source    rsp_ch
);

   seq_state_type state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic          blink_on_ff, blink_on_in;
   logic [7:0]    blink_level_ff, blink_level_in;
   logic [7:0]    base_level_ff, base_level_in;
   logic [31:0]   now_ff, now_in;
   logic [31:0]   blink_mark_ff, blink_mark_in;
   logic [15:0]   cont_half_ff, cont_half_in;
   logic          pending_ff, pending_in;
   logic [7:0]    br_from_ff, br_from_in;
   logic [7:0]    br_to_ff, br_to_in;
   logic [15:0]   br_len_ff, br_len_in;
   logic [15:0]   br_limit_ff, br_limit_in;
   logic [15:0]   br_count_ff, br_count_in;
   logic [31:0]   br_mark_ff, br_mark_in;
   logic [15:0]   blink_time_ff;
   logic [7:0]    pend_duty_ff, pend_duty_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_duty_ff, rsp_duty_in;

   logic [31:0]   blink_el;
   logic [31:0]   br_el;
   logic          br_wrap;
   logic [15:0]   count_next;
   logic          br_finish;
   blend_req_type blend_req;
   blend_rsp_type blend_rsp;

   lbbs_blend #(
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .blend_req (blend_req),
      .blend_rsp (blend_rsp)
   );

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.duty  = rsp_duty_ff;

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      blink_on_in    = blink_on_ff;
      blink_level_in = blink_level_ff;
      base_level_in  = base_level_ff;
      now_in         = now_ff;
      blink_mark_in  = blink_mark_ff;
      cont_half_in   = cont_half_ff;
      pending_in     = pending_ff;
      br_from_in     = br_from_ff;
      br_to_in       = br_to_ff;
      br_len_in      = br_len_ff;
      br_limit_in    = br_limit_ff;
      br_count_in    = br_count_ff;
      br_mark_in     = br_mark_ff;
      pend_duty_in   = pend_duty_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_duty_in    = rsp_duty_ff;
      req_ch.ready   = 1'b0;

      blink_el   = now_ff - blink_mark_ff;
      br_el      = now_ff - br_mark_ff;
      br_wrap    = (br_el >= {16'd0, br_len_ff});
      count_next = br_count_ff + 16'd1;
      // a negative limit other than endless ends at the first wrap
      br_finish  = br_wrap && (br_limit_ff != LOOP_ENDLESS) &&
                   (br_limit_ff[15] || (count_next >= br_limit_ff));

      blend_req.start    = 1'b0;
      blend_req.elapsed  = br_wrap ? 16'd0 : br_el[15:0];
      blend_req.len      = br_len_ff;
      blend_req.from_lvl = br_from_ff;
      blend_req.to_lvl   = br_to_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = !reset;
            if (req_ch.valid && !reset) begin
               unique case (opcode_type'(req_ch.opcode))
                  OP_TICK: begin
                     now_in   = now_ff + 32'd1;
                     state_in = ST_TICK;
                  end
                  OP_SET_VALUE: begin
                     base_level_in = req_ch.color;
                     if (mode_ff == MODE_SOLID) begin
                        pend_duty_in = req_ch.color;
                        state_in     = ST_EMIT;
                     end
                  end
                  OP_SET_SOLID: begin
                     mode_in       = MODE_SOLID;
                     base_level_in = req_ch.color;
                     pend_duty_in  = req_ch.color;
                     state_in      = ST_EMIT;
                  end
                  OP_BLINK_ONCE, OP_BLINK_TWICE, OP_BLINK_CONT: begin
                     blink_level_in = req_ch.color;
                     blink_mark_in  = now_ff;
                     blink_on_in    = 1'b1;
                     pend_duty_in   = req_ch.color;
                     state_in       = ST_EMIT;
                     if (opcode_type'(req_ch.opcode) == OP_BLINK_ONCE) begin
                        mode_in = MODE_ONCE;
                     end else if (opcode_type'(req_ch.opcode) == OP_BLINK_TWICE) begin
                        mode_in = MODE_TWICE;
                     end else begin
                        mode_in      = MODE_CONT;
                        cont_half_in = req_ch.duration_ms;
                     end
                  end
                  OP_BREATHE: begin
                     if (req_ch.loop_limit != 16'sd0) begin
                        br_len_in   = (req_ch.period_ms == 16'd0) ? 16'd1 : req_ch.period_ms;
                        br_limit_in = req_ch.loop_limit;
                        br_from_in  = req_ch.color;
                        br_to_in    = req_ch.end_color;
                        br_count_in = '0;
                        br_mark_in  = now_ff;
                        // queued behind a one-shot or double blink
                        if (mode_ff == MODE_ONCE || mode_ff == MODE_TWICE) begin
                           pending_in = 1'b1;
                        end else begin
                           mode_in      = MODE_BREATHE;
                           pend_duty_in = req_ch.color;
                           state_in     = ST_EMIT;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     mode_in        = MODE_SOLID;
                     blink_on_in    = 1'b0;
                     blink_level_in = '0;
                     blink_mark_in  = '0;
                     base_level_in  = '0;
                     pending_in     = 1'b0;
                     pend_duty_in   = '0;
                     state_in       = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_TICK: begin
            state_in = ST_IDLE;
            unique case (mode_ff)
               MODE_ONCE, MODE_TWICE: begin
                  if (blink_el >= {16'd0, blink_time_ff}) begin
                     state_in = ST_EMIT;
                     if (mode_ff == MODE_TWICE && blink_on_ff) begin
                        blink_on_in   = 1'b0;
                        blink_mark_in = now_ff;
                        pend_duty_in  = '0;
                     end else if (mode_ff == MODE_TWICE) begin
                        blink_on_in   = 1'b1;
                        blink_mark_in = now_ff;
                        mode_in       = MODE_ONCE;
                        pend_duty_in  = blink_level_ff;
                     end else begin
                        blink_on_in    = 1'b0;
                        blink_mark_in  = '0;
                        blink_level_in = '0;
                        mode_in        = pending_ff ? MODE_BREATHE : MODE_SOLID;
                        pend_duty_in   = base_level_ff;
                     end
                  end
               end
               MODE_CONT: begin
                  if (blink_el >= {16'd0, cont_half_ff}) begin
                     blink_on_in   = !blink_on_ff;
                     blink_mark_in = now_ff;
                     pend_duty_in  = blink_on_ff ? 8'd0 : blink_level_ff;
                     state_in      = ST_EMIT;
                  end
               end
               MODE_BREATHE: begin
                  if (br_wrap) begin
                     br_mark_in = now_ff;
                     if (br_limit_ff != LOOP_ENDLESS) begin
                        br_count_in = count_next;
                     end
                  end
                  if (br_finish) begin
                     mode_in      = MODE_SOLID;
                     pend_duty_in = base_level_ff;
                     state_in     = ST_EMIT;
                  end else begin
                     blend_req.start = 1'b1;
                     state_in        = ST_BLEND;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_BLEND: begin
            if (blend_rsp.done) begin
               pend_duty_in = blend_rsp.duty;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // output register free or draining this cycle
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_duty_in  = pend_duty_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         mode_ff        <= MODE_SOLID;
         blink_on_ff    <= 1'b0;
         blink_level_ff <= '0;
         base_level_ff  <= '0;
         now_ff         <= '0;
         blink_mark_ff  <= '0;
         cont_half_ff   <= '0;
         pending_ff     <= 1'b0;
         br_from_ff     <= '0;
         br_to_ff       <= '0;
         br_len_ff      <= 16'd1;
         br_limit_ff    <= '0;
         br_count_ff    <= '0;
         br_mark_ff     <= '0;
         blink_time_ff  <= BLINK_TIME_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         blink_on_ff    <= blink_on_in;
         blink_level_ff <= blink_level_in;
         base_level_ff  <= base_level_in;
         now_ff         <= now_in;
         blink_mark_ff  <= blink_mark_in;
         cont_half_ff   <= cont_half_in;
         pending_ff     <= pending_in;
         br_from_ff     <= br_from_in;
         br_to_ff       <= br_to_in;
         br_len_ff      <= br_len_in;
         br_limit_ff    <= br_limit_in;
         br_count_ff    <= br_count_in;
         br_mark_ff     <= br_mark_in;
         if (csr_we) begin
            blink_time_ff <= csr_wdata;
         end
         rsp_valid_ff   <= rsp_valid_in;
      end
      pend_duty_ff <= pend_duty_in;
      rsp_duty_ff  <= rsp_duty_in;
   end

endmodule
